[rtl/core/prwc_pkg.sv]
`default_nettype none
package prwc_pkg;

   localparam int FRAME_SIDE   = 64;
   localparam int WINDOW_SIDE  = 7;
   localparam int PIXEL_BITS   = 16;
   localparam int THRESH_BITS  = 16;
   localparam int FRAC_BITS    = 8;

   localparam int FRAME_PIXELS = FRAME_SIDE * FRAME_SIDE;
   localparam int WIN_HALF     = (WINDOW_SIDE - 1) / 2;
   localparam int COORD_W      = $clog2(FRAME_SIDE);
   localparam int ADDR_W       = $clog2(FRAME_PIXELS);
   localparam int WIN_CNT_W    = $clog2(WINDOW_SIDE);
   localparam int WEIGHT_W     = PIXEL_BITS + $clog2(WINDOW_SIDE * WINDOW_SIDE);
   localparam int MOMENT_W     = WEIGHT_W + COORD_W;
   localparam int CENT_W       = COORD_W + FRAC_BITS;
   localparam int NUM_W        = MOMENT_W + FRAC_BITS;
   localparam int DIV_CNT_W    = $clog2(NUM_W + 1);

   typedef struct packed {
      logic [PIXEL_BITS-1:0] value;
      logic [COORD_W-1:0]    row;
      logic [COORD_W-1:0]    col;
   } peak_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [MOMENT_W-1:0] row_moment;
      logic [MOMENT_W-1:0] col_moment;
   } sums_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WINDOW,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

endpackage
`default_nettype wire

[rtl/core/prwc_frame_store.sv]
`default_nettype none
module prwc_frame_store (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [prwc_pkg::PIXEL_BITS-1:0] pixel,
   input  wire logic                         start_of_frame,
   input  wire logic [prwc_pkg::ADDR_W-1:0]  rd_addr,
   output logic [prwc_pkg::PIXEL_BITS-1:0]   rd_data,
   output prwc_pkg::peak_type                peak,
   output logic                              frame_last
);
   import prwc_pkg::*;

   logic [PIXEL_BITS-1:0] mem [FRAME_PIXELS];
   logic [PIXEL_BITS-1:0] rd_data_ff;

   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   peak_type           peak_ff, peak_in;

   logic [COORD_W-1:0] eff_row, eff_col;
   logic [ADDR_W-1:0]  eff_addr;
   logic               pos_zero;
   peak_type           base;

   assign eff_row  = start_of_frame ? '0 : row_ff;
   assign eff_col  = start_of_frame ? '0 : col_ff;
   assign eff_addr = start_of_frame ? '0 : addr_ff;
   assign pos_zero = (eff_addr == '0);
   assign frame_last = wr_en && (eff_row == COORD_W'(FRAME_SIDE - 1))
                       && (eff_col == COORD_W'(FRAME_SIDE - 1));

   always_comb begin
      base    = pos_zero ? '0 : peak_ff;
      peak_in = peak_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      addr_in = addr_ff;
      if (wr_en) begin
         peak_in = base;
         if (pixel > base.value) begin
            peak_in.value = pixel;
            peak_in.row   = eff_row;
            peak_in.col   = eff_col;
         end
         if (frame_last) begin
            row_in  = '0;
            col_in  = '0;
            addr_in = '0;
         end else begin
            addr_in = eff_addr + ADDR_W'(1);
            if (eff_col == COORD_W'(FRAME_SIDE - 1)) begin
               col_in = '0;
               row_in = eff_row + COORD_W'(1);
            end else begin
               col_in = eff_col + COORD_W'(1);
               row_in = eff_row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         addr_ff <= '0;
         peak_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         addr_ff <= addr_in;
         peak_ff <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[eff_addr] <= pixel;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign peak    = peak_ff;

endmodule
`default_nettype wire

[rtl/core/prwc_window_acc.sv]
`default_nettype none
module prwc_window_acc (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire prwc_pkg::peak_type              peak,
   input  wire logic [prwc_pkg::THRESH_BITS-1:0] threshold,
   output logic [prwc_pkg::ADDR_W-1:0]          rd_addr,
   input  wire logic [prwc_pkg::PIXEL_BITS-1:0] rd_data,
   output prwc_pkg::sums_type                   sums,
   output logic                                 done
);
   import prwc_pkg::*;

   localparam int SPOS_W = COORD_W + 2;

   logic                 active_ff, active_in;
   logic [WIN_CNT_W-1:0] wr_ff, wr_in, wc_ff, wc_in;
   logic                 hit_ff, tail_ff, done_ff;
   logic [COORD_W-1:0]   row_ff, col_ff;
   sums_type             sums_ff, sums_in;

   logic [SPOS_W-1:0] r_pos, c_pos;
   logic              r_ok, c_ok, last_issue, keep;
   logic [PIXEL_BITS+COORD_W-1:0] row_prod, col_prod;

   assign r_pos = SPOS_W'(peak.row) - SPOS_W'(WIN_HALF) + SPOS_W'(wr_ff);
   assign c_pos = SPOS_W'(peak.col) - SPOS_W'(WIN_HALF) + SPOS_W'(wc_ff);
   assign r_ok  = !r_pos[SPOS_W-1] && (r_pos < SPOS_W'(FRAME_SIDE));
   assign c_ok  = !c_pos[SPOS_W-1] && (c_pos < SPOS_W'(FRAME_SIDE));
   assign rd_addr = ADDR_W'(r_pos[COORD_W-1:0]) * ADDR_W'(FRAME_SIDE)
                    + ADDR_W'(c_pos[COORD_W-1:0]);
   assign last_issue = active_ff && (wr_ff == WIN_CNT_W'(WINDOW_SIDE - 1))
                       && (wc_ff == WIN_CNT_W'(WINDOW_SIDE - 1));

   assign keep     = hit_ff && (32'(rd_data) >= 32'(threshold));
   assign row_prod = (PIXEL_BITS+COORD_W)'(rd_data) * (PIXEL_BITS+COORD_W)'(row_ff);
   assign col_prod = (PIXEL_BITS+COORD_W)'(rd_data) * (PIXEL_BITS+COORD_W)'(col_ff);

   always_comb begin
      active_in = active_ff;
      wr_in     = wr_ff;
      wc_in     = wc_ff;
      sums_in   = sums_ff;
      if (start) begin
         active_in = 1'b1;
         wr_in     = '0;
         wc_in     = '0;
         sums_in   = '0;
      end else begin
         if (active_ff) begin
            if (wc_ff == WIN_CNT_W'(WINDOW_SIDE - 1)) begin
               wc_in = '0;
               wr_in = wr_ff + WIN_CNT_W'(1);
            end else begin
               wc_in = wc_ff + WIN_CNT_W'(1);
            end
            if (last_issue) begin
               active_in = 1'b0;
            end
         end
         if (keep) begin
            sums_in.weight     = sums_ff.weight + WEIGHT_W'(rd_data);
            sums_in.row_moment = sums_ff.row_moment + MOMENT_W'(row_prod);
            sums_in.col_moment = sums_ff.col_moment + MOMENT_W'(col_prod);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         hit_ff    <= 1'b0;
         tail_ff   <= 1'b0;
         done_ff   <= 1'b0;
         sums_ff   <= '0;
      end else begin
         active_ff <= active_in;
         hit_ff    <= active_ff && r_ok && c_ok && !start;
         tail_ff   <= last_issue && !start;
         done_ff   <= tail_ff;
         sums_ff   <= sums_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ff  <= wr_in;
      wc_ff  <= wc_in;
      row_ff <= r_pos[COORD_W-1:0];
      col_ff <= c_pos[COORD_W-1:0];
   end

   assign sums = sums_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

[rtl/core/prwc_divider.sv]
`default_nettype none
module prwc_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [prwc_pkg::MOMENT_W-1:0] moment,
   input  wire logic [prwc_pkg::WEIGHT_W-1:0] weight,
   output logic [prwc_pkg::CENT_W-1:0]        quotient,
   output logic                               done
);
   import prwc_pkg::*;

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [WEIGHT_W-1:0]  rem_ff, rem_in, div_ff, div_in;
   logic [CENT_W-1:0]    quo_ff, quo_in;

   logic [WEIGHT_W:0] trial, diff;
   logic              ge;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(NUM_W);
         num_in  = {moment, FRAC_BITS'(0)};
         rem_in  = '0;
         div_in  = weight;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         rem_in = ge ? diff[WEIGHT_W-1:0] : trial[WEIGHT_W-1:0];
         quo_in = {quo_ff[CENT_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

[rtl/core/peak_roi_weighted_centroid.sv]
`default_nettype none
// channel  direction  handshake          payload
// req      in         req_valid/stall    pixel_value, start_of_frame
// rsp      out        rsp_valid/stall    found, centroid_row/col, peak_value/row/col
// csr      in         csr_valid/ready    threshold_level
//
// one pixel a cycle while a frame streams in; the last pixel of a frame starts
// a window pass over WINDOW_SIDE x WINDOW_SIDE pixels through the frame store read port,
// then a shift-subtract divide (skipped on zero weight), and then the output
// register is loaded.
// req_stall is high after the last pixel until the output register is loaded,
// longer if rsp is stalled.
// synchronous reset clears counters, peak, threshold and control; no clearing pass.
module peak_roi_weighted_centroid (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [prwc_pkg::PIXEL_BITS-1:0]   req_pixel_value,
   input  wire logic                              req_start_of_frame,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_found,
   output logic [prwc_pkg::CENT_W-1:0]            rsp_centroid_row,
   output logic [prwc_pkg::CENT_W-1:0]            rsp_centroid_col,
   output logic [prwc_pkg::PIXEL_BITS-1:0]        rsp_peak_value,
   output logic [prwc_pkg::COORD_W-1:0]           rsp_peak_row,
   output logic [prwc_pkg::COORD_W-1:0]           rsp_peak_col,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [prwc_pkg::THRESH_BITS-1:0]  csr_threshold_level
);
   import prwc_pkg::*;

   state_type state_ff, state_in;

   logic [THRESH_BITS-1:0] threshold_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff;
   logic [CENT_W-1:0]      cent_row_ff, cent_col_ff;
   peak_type               peak_out_ff;

   logic                  accept, frame_last, win_start, win_done;
   logic                  div_start, div_done, div_col_done, out_load, nonzero;
   logic [ADDR_W-1:0]     rd_addr;
   logic [PIXEL_BITS-1:0] rd_data;
   peak_type              peak;
   sums_type              sums;
   logic [CENT_W-1:0]     quo_row, quo_col;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign nonzero   = (sums.weight != '0);

   prwc_frame_store u_store (
      .clock          (clock),
      .reset          (reset),
      .wr_en          (accept),
      .pixel          (req_pixel_value),
      .start_of_frame (req_start_of_frame),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .peak           (peak),
      .frame_last     (frame_last)
   );

   prwc_window_acc u_window (
      .clock     (clock),
      .reset     (reset),
      .start     (win_start),
      .peak      (peak),
      .threshold (threshold_ff),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .sums      (sums),
      .done      (win_done)
   );

   prwc_divider u_div_row (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .moment   (sums.row_moment),
      .weight   (sums.weight),
      .quotient (quo_row),
      .done     (div_done)
   );

   prwc_divider u_div_col (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .moment   (sums.col_moment),
      .weight   (sums.weight),
      .quotient (quo_col),
      .done     (div_col_done)
   );

   always_comb begin
      state_in  = state_ff;
      win_start = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && frame_last) begin
               win_start = 1'b1;
               state_in  = ST_WINDOW;
            end
         end
         ST_WINDOW: begin
            if (win_done) begin
               if (nonzero) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  state_in = ST_OUTPUT;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done && div_col_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_threshold_level;
         end
      end
   end

   // result response register
   always_ff @(posedge clock) begin
      if (out_load) begin
         found_ff    <= nonzero;
         cent_row_ff <= nonzero ? quo_row : '0;
         cent_col_ff <= nonzero ? quo_col : '0;
         peak_out_ff <= peak;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_centroid_row = cent_row_ff;
   assign rsp_centroid_col = cent_col_ff;
   assign rsp_peak_value   = peak_out_ff.value;
   assign rsp_peak_row     = peak_out_ff.row;
   assign rsp_peak_col     = peak_out_ff.col;

endmodule
`default_nettype wire
